// ===== hdl/frame_time_budget_monitor_defines.svh =====
// ----------------------------------------------------------------------------
// frame_time_budget_monitor_defines
// assertion macros shared by the frame time budget monitor modules
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_BUDGET_MONITOR_DEFINES_SVH
`define FRAME_TIME_BUDGET_MONITOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FTBM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftbm assertion failed");

// next-cycle implication, disabled during reset
`define FTBM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftbm assertion failed");

`endif

// ===== hdl/ftbm_pkg.sv =====
// ----------------------------------------------------------------------------
// ftbm_pkg
// shared constants and types of the frame time budget monitor
// ----------------------------------------------------------------------------
package ftbm_pkg;

  localparam int WINDOW_DEFAULT = 64;

  localparam int SAMPLE_W  = 20;
  localparam int STAMP_W   = 32;
  localparam int BUDGET_W  = 20;
  localparam int MINCNT_W  = 7;
  localparam int SUSTAIN_W = 16;
  localparam int OCOUNT_W  = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BUDGET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINCNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;

  localparam logic [BUDGET_W-1:0]  BUDGET_RESET  = 20'd40000;
  localparam logic [MINCNT_W-1:0]  MINCNT_RESET  = 7'd30;
  localparam logic [SUSTAIN_W-1:0] SUSTAIN_RESET = 16'd3000;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/ftbm_ram.sv =====
// ----------------------------------------------------------------------------
// ftbm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ftbm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ftbm_divider.sv =====
// ----------------------------------------------------------------------------
// ftbm_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "frame_time_budget_monitor_defines.svh"

module ftbm_divider #(
  parameter int SUM_W = 26,
  parameter int DIV_W = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic [SUM_W-1:0]   quotient,
  output ftbm_pkg::div_stat_t stat
);

  localparam int ITER_W = $clog2(SUM_W + 1);
  localparam logic [ITER_W-1:0] ITERS = ITER_W'(SUM_W);

  logic [SUM_W-1:0]  quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [ITER_W-1:0] iter;
  logic              busy;
  logic              done;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, quo[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITERS;
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DIV_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  `FTBM_ASSERT_IMP(a_start_idle, clk, rst, start, !busy)
  `FTBM_ASSERT_NXT(a_start_busy, clk, rst, start, busy)
  `FTBM_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)

endmodule

// ===== hdl/frame_time_budget_monitor.sv =====
// ----------------------------------------------------------------------------
// frame_time_budget_monitor
// sliding-window average of frame times with a sustained over-budget warning
// ----------------------------------------------------------------------------
//  channel   group                   direction  contents
//  input     s_axis_tvalid/tready    in         frame time, timestamp
//  output    m_axis_tvalid/tready    out        average, count, flags
//  config    cfg_valid/cfg_ready     in         register index, write data
//
//  one item at a time: the next item is accepted only once the last one has
//  passed the update, bit-serial sum / count divider and finish steps
//  the ring is in a ram; slots not yet written read as zero through the fill
//  count, so there is no clearing pass after reset
//  a result waiting in the output register stalls only the final step of the
//  next request; config writes are always taken
// ----------------------------------------------------------------------------
`include "frame_time_budget_monitor_defines.svh"

module frame_time_budget_monitor #(
  parameter int WINDOW = ftbm_pkg::WINDOW_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [19:0] frame_time_us, [51:20] now_ms, [55:52] zero
  input  logic [ftbm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [19:0] average_us, [26:20] sample_count, [27] over_budget, [28] warning,
  // [31:29] zero
  output logic [ftbm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ftbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ftbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = ftbm_pkg::SAMPLE_W + SLOT_W;
  localparam int CMP_W  = CNT_W + ftbm_pkg::MINCNT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_DIV    = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [ftbm_pkg::BUDGET_W-1:0]  budget_us;
  logic [ftbm_pkg::MINCNT_W-1:0]  min_samples;
  logic [ftbm_pkg::SUSTAIN_W-1:0] sustain_ms;

  logic [ftbm_pkg::SAMPLE_W-1:0] sample;
  logic [ftbm_pkg::STAMP_W-1:0]  now_ms;
  logic [SLOT_W-1:0]             write_slot;
  logic [CNT_W-1:0]              filled_count;
  logic [SUM_W-1:0]              window_sum;
  logic                          over_started;
  logic [ftbm_pkg::STAMP_W-1:0]  over_start_ms;
  logic                          already_warned;

  logic                          out_valid;
  logic [ftbm_pkg::SAMPLE_W-1:0] out_avg;
  logic [ftbm_pkg::OCOUNT_W-1:0] out_count;
  logic                          out_over;
  logic                          out_warn;

  logic [ftbm_pkg::SAMPLE_W-1:0] ring_rdata;
  logic [ftbm_pkg::SAMPLE_W-1:0] oldest;
  logic [SUM_W-1:0]              window_sum_next;
  logic [CNT_W-1:0]              filled_count_next;
  logic                          ring_we;
  logic                          div_start;
  logic [SUM_W-1:0]              quotient;
  ftbm_pkg::div_stat_t           div_stat;

  logic                          in_accept;
  logic                          out_free;
  logic [ftbm_pkg::SAMPLE_W-1:0] avg;
  logic [CMP_W-1:0]              fill_ext;
  logic [CMP_W-1:0]              min_ext;
  logic [ftbm_pkg::STAMP_W-1:0]  elapsed;
  logic                          over;
  logic                          warn;
  logic [CNT_W+ftbm_pkg::OCOUNT_W-1:0] count_ext;

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_us   <= ftbm_pkg::BUDGET_RESET;
      min_samples <= ftbm_pkg::MINCNT_RESET;
      sustain_ms  <= ftbm_pkg::SUSTAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ftbm_pkg::REG_BUDGET:  budget_us   <= cfg_data[ftbm_pkg::BUDGET_W-1:0];
        ftbm_pkg::REG_MINCNT:  min_samples <= cfg_data[ftbm_pkg::MINCNT_W-1:0];
        ftbm_pkg::REG_SUSTAIN: sustain_ms  <= cfg_data[ftbm_pkg::SUSTAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // the slot being replaced holds data only once the ring has wrapped
  assign oldest = (filled_count == FULL_CNT) ? ring_rdata : '0;
  assign window_sum_next = window_sum
                         + {{(SUM_W - ftbm_pkg::SAMPLE_W){1'b0}}, sample}
                         - {{(SUM_W - ftbm_pkg::SAMPLE_W){1'b0}}, oldest};
  assign filled_count_next = (filled_count == FULL_CNT) ? filled_count
                                                        : filled_count + 1'b1;
  assign ring_we   = (state == S_UPDATE);
  assign div_start = (state == S_UPDATE);

  ftbm_ram #(
    .WIDTH (ftbm_pkg::SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (sample),
    .raddr (write_slot),
    .rdata (ring_rdata)
  );

  ftbm_divider #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum_next),
    .divisor  (filled_count_next),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // average of 20-bit samples always fits 20 bits
  assign avg      = quotient[ftbm_pkg::SAMPLE_W-1:0];
  assign fill_ext = {{ftbm_pkg::MINCNT_W{1'b0}}, filled_count};
  assign min_ext  = {{CNT_W{1'b0}}, min_samples};
  assign over     = (avg > budget_us) && (fill_ext >= min_ext);
  assign elapsed  = now_ms - over_start_ms;
  // the first over-budget item only records the start time
  assign warn     = over && over_started && !already_warned
                 && (elapsed >= {{(ftbm_pkg::STAMP_W - ftbm_pkg::SUSTAIN_W){1'b0}},
                                 sustain_ms});
  assign count_ext = {{ftbm_pkg::OCOUNT_W{1'b0}}, filled_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      write_slot     <= '0;
      filled_count   <= '0;
      window_sum     <= '0;
      over_started   <= 1'b0;
      over_start_ms  <= '0;
      already_warned <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          window_sum   <= window_sum_next;
          filled_count <= filled_count_next;
          write_slot   <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
          state        <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if (over) begin
              if (!over_started) begin
                over_started  <= 1'b1;
                over_start_ms <= now_ms;
              end else if (warn) begin
                already_warned <= 1'b1;
              end
            end else begin
              over_started   <= 1'b0;
              already_warned <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample <= s_axis_tdata[ftbm_pkg::SAMPLE_W-1:0];
      now_ms <= s_axis_tdata[ftbm_pkg::SAMPLE_W +: ftbm_pkg::STAMP_W];
    end
    if (state == S_FINISH && out_free) begin
      out_avg   <= avg;
      out_count <= count_ext[ftbm_pkg::OCOUNT_W-1:0];
      out_over  <= over;
      out_warn  <= warn;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_warn, out_over, out_count, out_avg};

  `FTBM_ASSERT_NXT(a_accept_update, clk, rst, in_accept, state == S_UPDATE)
  `FTBM_ASSERT_IMP(a_done_in_div, clk, rst, div_stat.done, state == S_DIV)
  `FTBM_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, filled_count <= FULL_CNT)
  `FTBM_ASSERT_IMP(a_warn_needs_over, clk, rst, out_valid && out_warn, out_over)

endmodule
